// File: rtl/pinp_pkg.sv
// ----------------------------------------------------------------------------
// pinp_pkg
// Shared types and constants for the palette index nibble packer.
// ----------------------------------------------------------------------------
package pinp_pkg;

    localparam int PALETTE_SIZE = 16;
    localparam int SLOT_COUNT   = 16;
    localparam int PAL_CAP      = (PALETTE_SIZE < SLOT_COUNT) ? PALETTE_SIZE : SLOT_COUNT;
    localparam int IDX_W        = $clog2(SLOT_COUNT);
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
    localparam int COLOR_W      = 32;
    localparam int RGB_W        = 24;

    localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

    localparam logic [1:0] MODE_LEARN  = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [COLOR_W-1:0] first_color;
        logic [COLOR_W-1:0] second_color;
        logic               second_present;
        logic [3:0]         entry_select;
    } t_pinp_in;

    typedef struct packed {
        logic [7:0]       packed_byte;
        logic [RGB_W-1:0] entry_rgb;
        logic [4:0]       entry_count;
        logic             overflow_seen;
    } t_pinp_out;

    typedef struct packed {
        logic first_hit;
        logic second_hit;
    } t_lane_hit;

    typedef struct packed {
        logic             first_found;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] second_idx;
    } t_lookup;

endpackage

// File: rtl/pinp_lane.sv
// ----------------------------------------------------------------------------
// pinp_lane
// One palette slot comparator: matches the slot against both pixel colors.
// ----------------------------------------------------------------------------
module pinp_lane (
    input  logic [pinp_pkg::COLOR_W-1:0] i_entry,
    input  logic                         i_live,
    input  logic [pinp_pkg::COLOR_W-1:0] i_first,
    input  logic [pinp_pkg::COLOR_W-1:0] i_second,
    output pinp_pkg::t_lane_hit          o_hit
);
    import pinp_pkg::*;

    always_comb begin
        o_hit.first_hit  = i_live && (i_entry == i_first);
        o_hit.second_hit = i_live && (i_entry == i_second);
    end

endmodule

// File: rtl/pinp_merge.sv
// ----------------------------------------------------------------------------
// pinp_merge
// Combines lane hits into the lowest matching slot index for each color.
// ----------------------------------------------------------------------------
module pinp_merge (
    input  pinp_pkg::t_lane_hit [pinp_pkg::SLOT_COUNT-1:0] i_hits,
    output pinp_pkg::t_lookup                              o_lookup
);
    import pinp_pkg::*;

    logic [SLOT_COUNT-1:0] first_vec;
    logic [SLOT_COUNT-1:0] second_vec;
    logic [SLOT_COUNT-1:0] first_oh;
    logic [SLOT_COUNT-1:0] second_oh;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            first_vec[i]  = i_hits[i].first_hit;
            second_vec[i] = i_hits[i].second_hit;
        end
        // isolate lowest set bit
        first_oh  = first_vec & (~first_vec + SLOT_COUNT'(1));
        second_oh = second_vec & (~second_vec + SLOT_COUNT'(1));

        o_lookup.first_found = |first_vec;
        o_lookup.first_idx   = '0;
        o_lookup.second_idx  = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (first_oh[i]) begin
                o_lookup.first_idx = o_lookup.first_idx | IDX_W'(i);
            end
            if (second_oh[i]) begin
                o_lookup.second_idx = o_lookup.second_idx | IDX_W'(i);
            end
        end
    end

endmodule

// File: rtl/palette_index_nibble_packer.sv
// ----------------------------------------------------------------------------
// palette_index_nibble_packer
// Learns an RGBA palette in first-seen order and packs pixel pairs into
// 4-bit index nibbles; palette entries can also be read back.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while results are taken; its result
// appears in the output register on the next cycle. A new transaction is
// taken when the output register is empty or its result leaves in the same
// cycle, so a stalled result side stalls the input. Sixteen slot comparators
// search the palette in parallel and the lookup, append and count update all
// finish in the accepting cycle, so each transaction sees the palette left by
// the one before it. Throughput is one transaction per cycle while results
// are taken, set by the combinational compare and priority merge.
module palette_index_nibble_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pinp_pkg::t_pinp_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pinp_pkg::t_pinp_out o_out_data
);
    import pinp_pkg::*;

    logic [COLOR_W-1:0] r_palette [SLOT_COUNT];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_overflow;
    logic               n_overflow;
    logic               r_out_valid;
    t_pinp_out          r_out_data;
    t_pinp_out          n_out_data;

    logic                           accept;
    logic                           do_append;
    logic [COLOR_W-1:0]             second_eff;
    t_lane_hit [SLOT_COUNT-1:0]     hits;
    t_lookup                        lookup;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign second_eff = i_in_data.second_present ? i_in_data.second_color : OPAQUE_BLACK;

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
        pinp_lane u_lane (
            .i_entry  (r_palette[g]),
            .i_live   (CNT_W'(g) < r_count),
            .i_first  (i_in_data.first_color),
            .i_second (second_eff),
            .o_hit    (hits[g])
        );
    end

    pinp_merge u_merge (
        .i_hits   (hits),
        .o_lookup (lookup)
    );

    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        do_append  = 1'b0;
        n_out_data = '0;
        case (i_in_data.mode)
            MODE_LEARN: begin
                if (!lookup.first_found) begin
                    if (r_count < CNT_W'(PAL_CAP)) begin
                        do_append = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                end
            end
            MODE_ENCODE: begin
                n_out_data.packed_byte = {lookup.first_idx, lookup.second_idx};
            end
            MODE_READ: begin
                if (CNT_W'(i_in_data.entry_select) < r_count) begin
                    n_out_data.entry_rgb = r_palette[i_in_data.entry_select][COLOR_W-1:8];
                end
            end
            default: begin
            end
        endcase
        n_out_data.entry_count   = n_count;
        n_out_data.overflow_seen = n_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_overflow  <= n_overflow;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
            if (do_append) begin
                r_palette[r_count[IDX_W-1:0]] <= i_in_data.first_color;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PAL_CAP))
        else $error("palette count above capacity");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |=> r_overflow)
        else $error("overflow flag cleared without reset");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overflow) |-> (r_count == CNT_W'(PAL_CAP)))
        else $error("overflow set while palette has room");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("palette count moved by more than one");
`endif

endmodule
